// File: rtl/crast_pkg.sv
// ----------------------------------------------------------------------------
// crast_pkg: shared constants for the midpoint circle rasterizer
// Default coordinate width, decision constants and point count per step.
// ----------------------------------------------------------------------------
package crast_pkg;

  // Default signed width of a center coordinate
  localparam int COORD_BITS_DEF = 11;

  // Extra bits carried by the decision value beyond the coordinate width
  localparam int DEC_EXTRA_BITS = 5;

  // Midpoint decision constants
  localparam int DEC_INIT   = 3;   // initial decision is DEC_INIT - 2r
  localparam int DEC_ADD_X  = 6;   // added when only x advances
  localparam int DEC_ADD_XY = 10;  // added when x advances and y drops

  // Points per step (eight-way symmetry)
  localparam int POINTS_PER_STEP = 8;
  localparam int PIDX_BITS       = $clog2(POINTS_PER_STEP);

  // Order in which the eight symmetric points leave the block
  typedef enum logic [PIDX_BITS-1:0] {
    PT_XPA_YPB = 3'd0,
    PT_XPA_YMB = 3'd1,
    PT_XMA_YPB = 3'd2,
    PT_XMA_YMB = 3'd3,
    PT_XPB_YPA = 3'd4,
    PT_XPB_YMA = 3'd5,
    PT_XMB_YPA = 3'd6,
    PT_XMB_YMA = 3'd7
  } point_sel_t;

endpackage

// File: rtl/crast_ifs.sv
// ----------------------------------------------------------------------------
// crast_ifs: valid/ready channels of the circle rasterizer
// Request channel (start or tick items) and point channel.
// ----------------------------------------------------------------------------
interface crast_req_if #(
  parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [COORD_BITS-2:0]  radius;

  modport source (output valid, start_req, center_x, center_y, radius, input ready);
  modport sink   (input valid, start_req, center_x, center_y, radius, output ready);
endinterface

interface crast_pt_if #(
  parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [COORD_BITS:0]  point_x;
  logic signed [COORD_BITS:0]  point_y;
  logic                        last_of_step;
  logic                        circle_done;

  modport source (output valid, point_x, point_y, last_of_step, circle_done, input ready);
  modport sink   (input valid, point_x, point_y, last_of_step, circle_done, output ready);
endinterface

// File: rtl/circle_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_rasterizer: midpoint circle generator
// A start item loads center and radius and emits the first step; each tick
// item emits the next step as eight symmetric points.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                        | items
//  req     | in  | start_req, center_x, center_y, radius          | 1 per step
//  pts     | out | point_x, point_y, last_of_step, circle_done    | 8 per step
//
//  An accepted item updates x, y and the decision and lands in a step buffer;
//  the buffer feeds the point register one point per cycle unless pts stalls.
//  A tick while idle is taken and gives no points.
//  rst (synchronous) leaves the block idle with both buffers empty.
//  Stalls on pts hold the point register; req is taken again as soon as the
//  step buffer sends its eighth point.
// ----------------------------------------------------------------------------
module circle_rasterizer #(
  parameter int COORD_BITS = crast_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  crast_req_if.sink  req,
  crast_pt_if.source pts
);
  import crast_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int PW = COORD_BITS + 1;
  localparam int DW = COORD_BITS + DEC_EXTRA_BITS;
  localparam logic [PIDX_BITS-1:0] LAST_IDX = PIDX_BITS'(POINTS_PER_STEP - 1);

  // Circle state
  logic signed [CW-1:0] held_center_x;
  logic signed [CW-1:0] held_center_y;
  logic signed [CW-1:0] offset_a;
  logic signed [CW-1:0] offset_b;
  logic signed [DW-1:0] decision;
  logic                 active;

  // Step buffer
  logic                 step_valid;
  logic [PIDX_BITS-1:0] step_idx;
  logic signed [CW-1:0] step_cx;
  logic signed [CW-1:0] step_cy;
  logic signed [CW-1:0] step_a;
  logic signed [CW-1:0] step_b;
  logic                 step_done;

  // Point register
  logic                 out_valid;
  logic signed [PW-1:0] out_x;
  logic signed [PW-1:0] out_y;
  logic                 out_last;
  logic                 out_done;

  logic                 accept;
  logic                 gen;
  logic                 emit;
  logic signed [CW-1:0] cur_cx;
  logic signed [CW-1:0] cur_cy;
  logic signed [CW-1:0] cur_a;
  logic signed [CW-1:0] cur_b;
  logic signed [DW-1:0] cur_d;
  logic signed [CW-1:0] offset_a_next;
  logic signed [CW-1:0] offset_b_next;
  logic signed [DW-1:0] decision_next;
  logic                 done_next;
  logic signed [PW-1:0] pt_x;
  logic signed [PW-1:0] pt_y;
  logic signed [PW-1:0] ext_cx;
  logic signed [PW-1:0] ext_cy;
  logic signed [PW-1:0] ext_a;
  logic signed [PW-1:0] ext_b;

  // Handshake
  assign emit      = step_valid && (!out_valid || pts.ready);
  assign req.ready = !step_valid || (emit && (step_idx == LAST_IDX));
  assign accept    = req.valid && req.ready;
  assign gen       = req.start_req || active;

  // Values of this step: freshly loaded on start, else the held state
  always_comb begin
    if (req.start_req) begin
      cur_cx = req.center_x;
      cur_cy = req.center_y;
      cur_a  = '0;
      cur_b  = CW'({1'b0, req.radius});
      cur_d  = DW'(DEC_INIT) - (DW'({1'b0, req.radius}) <<< 1);
    end else begin
      cur_cx = held_center_x;
      cur_cy = held_center_y;
      cur_a  = offset_a;
      cur_b  = offset_b;
      cur_d  = decision;
    end
  end

  // Midpoint update
  always_comb begin
    offset_a_next = cur_a + CW'(1);
    if (cur_d < 0) begin
      offset_b_next = cur_b;
      decision_next = cur_d + (DW'(offset_a_next) <<< 2) + DW'(DEC_ADD_X);
    end else begin
      offset_b_next = cur_b - CW'(1);
      decision_next = cur_d + ((DW'(offset_a_next) - DW'(offset_b_next)) <<< 2)
                      + DW'(DEC_ADD_XY);
    end
    done_next = offset_a_next > offset_b_next;
  end

  // Point selection, wraps at PW bits
  assign ext_cx = PW'(step_cx);
  assign ext_cy = PW'(step_cy);
  assign ext_a  = PW'(step_a);
  assign ext_b  = PW'(step_b);

  always_comb begin
    case (point_sel_t'(step_idx))
      PT_XPA_YPB: begin pt_x = ext_cx + ext_a; pt_y = ext_cy + ext_b; end
      PT_XPA_YMB: begin pt_x = ext_cx + ext_a; pt_y = ext_cy - ext_b; end
      PT_XMA_YPB: begin pt_x = ext_cx - ext_a; pt_y = ext_cy + ext_b; end
      PT_XMA_YMB: begin pt_x = ext_cx - ext_a; pt_y = ext_cy - ext_b; end
      PT_XPB_YPA: begin pt_x = ext_cx + ext_b; pt_y = ext_cy + ext_a; end
      PT_XPB_YMA: begin pt_x = ext_cx + ext_b; pt_y = ext_cy - ext_a; end
      PT_XMB_YPA: begin pt_x = ext_cx - ext_b; pt_y = ext_cy + ext_a; end
      PT_XMB_YMA: begin pt_x = ext_cx - ext_b; pt_y = ext_cy - ext_a; end
      default:    begin pt_x = ext_cx;         pt_y = ext_cy;         end
    endcase
  end

  // State, step buffer and point register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_x <= '0;
      held_center_y <= '0;
      offset_a      <= '0;
      offset_b      <= '0;
      decision      <= '0;
      active        <= 1'b0;
      step_valid    <= 1'b0;
      step_idx      <= '0;
      out_valid     <= 1'b0;
    end else begin
      // point register
      if (emit) begin
        out_valid <= 1'b1;
        out_x     <= pt_x;
        out_y     <= pt_y;
        out_last  <= (step_idx == LAST_IDX);
        out_done  <= step_done;
      end else if (pts.ready) begin
        out_valid <= 1'b0;
      end

      // new step, else walk the step buffer
      if (accept && gen) begin
        held_center_x <= cur_cx;
        held_center_y <= cur_cy;
        offset_a      <= offset_a_next;
        offset_b      <= offset_b_next;
        decision      <= decision_next;
        active        <= !done_next;
        step_valid    <= 1'b1;
        step_idx      <= '0;
        step_cx       <= cur_cx;
        step_cy       <= cur_cy;
        step_a        <= cur_a;
        step_b        <= cur_b;
        step_done     <= done_next;
      end else if (emit) begin
        step_idx <= step_idx + PIDX_BITS'(1);
        if (step_idx == LAST_IDX) begin
          step_valid <= 1'b0;
        end
      end
    end
  end

  assign pts.valid        = out_valid;
  assign pts.point_x      = out_x;
  assign pts.point_y      = out_y;
  assign pts.last_of_step = out_last;
  assign pts.circle_done  = out_done;

endmodule
